FILE: hdl/hrlp_pkg.sv
// Shared types and constants for the HTTP request line parser.
`timescale 1ns / 1ps
`default_nettype none

package hrlp_pkg;

  localparam int unsigned MaxLineDef = 4096;
  localparam int unsigned OutW       = 13;
  localparam int unsigned DataW      = 8;
  localparam int unsigned TdataOutW  = 96;
  localparam int unsigned TuserOutW  = 4;

  localparam logic [DataW-1:0] ChSp = 8'h20;
  localparam logic [DataW-1:0] ChHt = 8'h09;
  localparam logic [DataW-1:0] ChCr = 8'h0D;
  localparam logic [DataW-1:0] ChVt = 8'h0B;
  localparam logic [DataW-1:0] ChFf = 8'h0C;
  localparam logic [DataW-1:0] ChLf = 8'h0A;

  typedef enum logic [2:0] {
    ErrNone      = 3'd0,
    ErrEmpty     = 3'd1,
    ErrAfterMeth = 3'd2,
    ErrAfterTgt  = 3'd3,
    ErrAfterVer  = 3'd4,
    ErrNoLf      = 3'd5
  } err_code_e;

  typedef struct packed {
    logic            line_ok;
    err_code_e       error_code;
    logic [OutW-1:0] method_start;
    logic [OutW-1:0] method_length;
    logic [OutW-1:0] target_start;
    logic [OutW-1:0] target_length;
    logic [OutW-1:0] version_start;
    logic [OutW-1:0] version_length;
    logic [OutW-1:0] line_end;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/hrlp_core.sv
// Per-byte request line state machine and token offset tracking.
`timescale 1ns / 1ps
`default_nettype none

module hrlp_core import hrlp_pkg::*; #(
  parameter int unsigned MAX_LINE = MaxLineDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [DataW-1:0] data_byte_i,
  input  wire logic             buffer_last_i,
  output      logic             emit_o,
  output      result_t          result_o
);

  localparam int unsigned PosW = $clog2(MAX_LINE + 1);
  localparam int unsigned CntW = (PosW > OutW) ? PosW : OutW;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_LINE);

  typedef enum logic [8:0] {
    PhSkip    = 9'b000000001,
    PhMethod  = 9'b000000010,
    PhWs1     = 9'b000000100,
    PhTarget  = 9'b000001000,
    PhWs2     = 9'b000010000,
    PhVersion = 9'b000100000,
    PhWs3     = 9'b001000000,
    PhNoLf    = 9'b010000000,
    PhDone    = 9'b100000000
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [CntW-1:0] pos_q, pos_d;
  logic [CntW-1:0] mbeg_q, mbeg_d, mcnt_q, mcnt_d;
  logic [CntW-1:0] tbeg_q, tbeg_d, tcnt_q, tcnt_d;
  logic [CntW-1:0] vbeg_q, vbeg_d, vcnt_q, vcnt_d;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (v >= MaxCnt) ? MaxCnt : v + 1'b1;
  endfunction

  logic            ws;
  logic            crlf;
  logic            ok_emit;
  logic [CntW-1:0] pos_inc;
  logic [CntW-1:0] end_val;
  err_code_e       code;

  assign ws   = (data_byte_i == ChSp) || (data_byte_i == ChHt) || (data_byte_i == ChCr) ||
                (data_byte_i == ChVt) || (data_byte_i == ChFf);
  assign crlf = (data_byte_i == ChCr) || (data_byte_i == ChLf);
  assign pos_inc = sat_inc(pos_q);

  always_comb begin
    phase_d = phase_q;
    mbeg_d  = mbeg_q;
    mcnt_d  = mcnt_q;
    tbeg_d  = tbeg_q;
    tcnt_d  = tcnt_q;
    vbeg_d  = vbeg_q;
    vcnt_d  = vcnt_q;
    ok_emit = 1'b0;
    unique case (phase_q)
      PhSkip: begin
        if (!crlf) begin
          mbeg_d  = pos_q;
          mcnt_d  = CntW'(1);
          phase_d = PhMethod;
        end
      end
      PhMethod: begin
        if (ws) phase_d = PhWs1;
        else    mcnt_d  = sat_inc(mcnt_q);
      end
      PhWs1: begin
        if (!ws) begin
          tbeg_d  = pos_q;
          tcnt_d  = CntW'(1);
          phase_d = PhTarget;
        end
      end
      PhTarget: begin
        if (ws) phase_d = PhWs2;
        else    tcnt_d  = sat_inc(tcnt_q);
      end
      PhWs2: begin
        if (!ws) begin
          vbeg_d  = pos_q;
          vcnt_d  = CntW'(1);
          phase_d = PhVersion;
        end
      end
      PhVersion: begin
        if (ws) phase_d = PhWs3;
        else    vcnt_d  = sat_inc(vcnt_q);
      end
      PhWs3: begin
        if (!ws) begin
          if (data_byte_i == ChLf) begin
            ok_emit = 1'b1;
            phase_d = PhDone;
          end else begin
            phase_d = PhNoLf;
          end
        end
      end
      PhNoLf, PhDone: begin
      end
      default: begin
      end
    endcase
  end

  // Error code follows the phase reached after this byte.
  always_comb begin
    unique case (phase_d)
      PhSkip:             code = ErrEmpty;
      PhMethod, PhWs1:    code = ErrAfterMeth;
      PhTarget, PhWs2:    code = ErrAfterTgt;
      PhVersion, PhWs3:   code = ErrAfterVer;
      default:            code = ErrNoLf;
    endcase
  end

  // Both the LF case and the buffer-length case end at pos + 1, saturated.
  assign end_val = pos_inc;

  assign emit_o = ok_emit || (buffer_last_i && (phase_d != PhDone));

  always_comb begin
    result_o.line_ok        = ok_emit;
    result_o.error_code     = ok_emit ? ErrNone : code;
    result_o.method_start   = mbeg_d[OutW-1:0];
    result_o.method_length  = mcnt_d[OutW-1:0];
    result_o.target_start   = tbeg_d[OutW-1:0];
    result_o.target_length  = tcnt_d[OutW-1:0];
    result_o.version_start  = vbeg_d[OutW-1:0];
    result_o.version_length = vcnt_d[OutW-1:0];
    result_o.line_end       = end_val[OutW-1:0];
  end

  assign pos_d = pos_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSkip;
      pos_q   <= '0;
      mbeg_q  <= '0;
      mcnt_q  <= '0;
      tbeg_q  <= '0;
      tcnt_q  <= '0;
      vbeg_q  <= '0;
      vcnt_q  <= '0;
    end else if (accept_i) begin
      if (buffer_last_i) begin
        phase_q <= PhSkip;
        pos_q   <= '0;
        mbeg_q  <= '0;
        mcnt_q  <= '0;
        tbeg_q  <= '0;
        tcnt_q  <= '0;
        vbeg_q  <= '0;
        vcnt_q  <= '0;
      end else begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        mbeg_q  <= mbeg_d;
        mcnt_q  <= mcnt_d;
        tbeg_q  <= tbeg_d;
        tcnt_q  <= tcnt_d;
        vbeg_q  <= vbeg_d;
        vcnt_q  <= vcnt_d;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/http_request_line_parser_unit.sv
// Top level of the HTTP request line parser: stream ports and result buffering.
`timescale 1ns / 1ps
`default_nettype none

// Takes one buffer byte per request on the slave side, with tlast on the final
// byte, and returns at most one result request per buffer on the master side.
// Leading CR/LF is skipped, then method, target and version tokens are located
// (whitespace is space, tab, CR, VT, FF); the byte after the version's trailing
// whitespace must be LF. A valid result goes out on the LF byte; otherwise an
// error result goes out on the tlast byte with line_end equal to the buffer
// length. Bytes after a valid result are ignored until tlast, which restarts
// the parser. Offsets and lengths saturate at MAX_LINE and are reported in 13
// bits. Throughput is one byte per cycle while s_axis_tready is high; the whole
// byte update is one pass through hrlp_core's phase logic into a registered result.
// The result register is backed by a one-entry skid, so s_axis_tready drops
// only when both hold results the master side has not yet taken.
module http_request_line_parser_unit import hrlp_pkg::*; #(
  parameter int unsigned MAX_LINE = MaxLineDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output      logic                 s_axis_tready,
  input  wire logic [DataW-1:0]     s_axis_tdata,   // [7:0] data_byte
  input  wire logic                 s_axis_tlast,   // buffer_last
  output      logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output      logic [TdataOutW-1:0] m_axis_tdata,   // method_start, method_length,
                                                    // target_start, target_length,
                                                    // version_start, version_length,
                                                    // line_end (13 bits each), zero pad
  output      logic [TuserOutW-1:0] m_axis_tuser    // [0] line_ok, [3:1] error_code
);

  logic    s_accept;
  logic    m_take;
  logic    core_emit;
  logic    res_emit;
  result_t core_res;

  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;

  assign s_axis_tready = !skid_valid_q;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_take        = out_valid_q && m_axis_tready;
  assign res_emit      = s_accept && core_emit;

  hrlp_core #(
    .MAX_LINE(MAX_LINE)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (s_accept),
    .data_byte_i  (s_axis_tdata),
    .buffer_last_i(s_axis_tlast),
    .emit_o       (core_emit),
    .result_o     (core_res)
  );

  // Output slot refills from the skid first; a new result lands in the skid
  // only when the slot is held.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_take) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= res_emit;
      end
    end else if (res_emit) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_take) begin
      out_q <= skid_valid_q ? skid_q : core_res;
    end else if (res_emit) begin
      skid_q <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = {out_q.error_code, out_q.line_ok};
  assign m_axis_tdata  = {5'b0, out_q.line_end, out_q.version_length, out_q.version_start,
                          out_q.target_length, out_q.target_start, out_q.method_length,
                          out_q.method_start};

endmodule

`default_nettype wire

FILE: test/http_request_line_parser_unit_tb.sv
// Self-checking testbench for the HTTP request line parser unit.
`timescale 1ns / 1ps

module http_request_line_parser_unit_tb;
  import hrlp_pkg::*;

  localparam int unsigned WatchLimit  = 2000;  // cycles with no request moving
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned RandomBytes = 420;
  localparam int unsigned HoldAfter   = 120;   // bytes in before the long stall
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned MaxPrinted  = 40;

  typedef enum logic [3:0] {
    PhSkip, PhMethod, PhWs1, PhTarget, PhWs2, PhVersion, PhWs3, PhNoLf, PhDone
  } phase_e;

  typedef struct packed {
    logic [DataW-1:0] data;
    logic             last;
  } byte_req_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [DataW-1:0]     s_axis_tdata  = '0;
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TdataOutW-1:0] m_axis_tdata;
  logic [TuserOutW-1:0] m_axis_tuser;

  http_request_line_parser_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Stimulus and expected results
  byte_req_t        pending_bytes[$];
  logic [DataW-1:0] line_q[$];
  result_t          expected_lines[$];
  int unsigned      total_bytes;
  int unsigned      bytes_accepted = 0;
  int unsigned      error_count = 0;

  // Parser state mirrored by the predictor
  phase_e          ph;
  logic [OutW-1:0] cur_pos, meth_at, meth_len, tgt_at, tgt_len, ver_at, ver_len;
  logic            line_done;

  // Sender and receiver pacing
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned rx_tick = 0;
  int unsigned rx_mode = 0;
  int unsigned hold_count = 0;
  logic        hold_off = 1'b0;
  int unsigned idle_cycles = 0;

  function automatic logic is_blank(logic [DataW-1:0] c);
    return c == ChSp || c == ChHt || c == ChCr || c == ChVt || c == ChFf;
  endfunction

  function automatic logic [OutW-1:0] sat_step(logic [OutW-1:0] v);
    return (v >= MaxLineDef) ? OutW'(MaxLineDef) : v + 1'b1;
  endfunction

  task automatic clear_parser();
    ph        = PhSkip;
    cur_pos   = '0;
    meth_at   = '0;
    meth_len  = '0;
    tgt_at    = '0;
    tgt_len   = '0;
    ver_at    = '0;
    ver_len   = '0;
    line_done = 1'b0;
  endtask

  function automatic result_t line_result(logic ok, err_code_e code, logic [OutW-1:0] end_at);
    result_t r;
    r.line_ok        = ok;
    r.error_code     = code;
    r.method_start   = meth_at;
    r.method_length  = meth_len;
    r.target_start   = tgt_at;
    r.target_length  = tgt_len;
    r.version_start  = ver_at;
    r.version_length = ver_len;
    r.line_end       = end_at;
    return r;
  endfunction

  // Advance the mirrored parser by one byte; queue the line result it yields.
  task automatic parse_byte(input logic [DataW-1:0] b, input logic last);
    logic [OutW-1:0] pos;
    logic            blank;
    err_code_e       code;
    pos     = cur_pos;
    blank   = is_blank(b);
    cur_pos = sat_step(pos);
    if (!line_done) begin
      case (ph)
        PhSkip: begin
          if (b != ChCr && b != ChLf) begin
            meth_at  = pos;
            meth_len = 1;
            ph       = PhMethod;
          end
        end
        PhMethod: if (blank) ph = PhWs1; else meth_len = sat_step(meth_len);
        PhWs1: begin
          if (!blank) begin
            tgt_at  = pos;
            tgt_len = 1;
            ph      = PhTarget;
          end
        end
        PhTarget: if (blank) ph = PhWs2; else tgt_len = sat_step(tgt_len);
        PhWs2: begin
          if (!blank) begin
            ver_at  = pos;
            ver_len = 1;
            ph      = PhVersion;
          end
        end
        PhVersion: if (blank) ph = PhWs3; else ver_len = sat_step(ver_len);
        PhWs3: begin
          if (!blank) begin
            if (b == ChLf) begin
              expected_lines.push_back(line_result(1'b1, ErrNone, sat_step(pos)));
              line_done = 1'b1;
              ph        = PhDone;
            end else begin
              ph = PhNoLf;
            end
          end
        end
        default: ;
      endcase
      // Buffer ran out before a complete line: code follows the phase reached
      if (last && !line_done) begin
        case (ph)
          PhSkip:              code = ErrEmpty;
          PhMethod, PhWs1:     code = ErrAfterMeth;
          PhTarget, PhWs2:     code = ErrAfterTgt;
          PhVersion, PhWs3:    code = ErrAfterVer;
          default:             code = ErrNoLf;
        endcase
        expected_lines.push_back(line_result(1'b0, code, cur_pos));
      end
    end
    if (last) clear_parser();
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned wanted);
    if (error_count < MaxPrinted)
      $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, wanted);
    error_count++;
  endtask

  function automatic string slot_name(int k);
    case (k)
      0: return "line_ok";
      1: return "error_code";
      2: return "method_start";
      3: return "method_length";
      4: return "target_start";
      5: return "target_length";
      6: return "version_start";
      7: return "version_length";
      default: return "line_end";
    endcase
  endfunction

  // Buffer building helpers
  task automatic add_byte(input logic [DataW-1:0] b);
    line_q.push_back(b);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  function automatic logic [DataW-1:0] token_char();
    logic [DataW-1:0] c;
    c = DataW'($urandom_range(0, 255));
    // LF may sit inside a token, but keep it rare
    while (is_blank(c) || (c == ChLf && $urandom_range(0, 7) != 0))
      c = DataW'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic add_token(input int unsigned lo, input int unsigned hi);
    repeat ($urandom_range(lo, hi)) add_byte(token_char());
  endtask

  task automatic add_blanks(input int unsigned lo, input int unsigned hi);
    repeat ($urandom_range(lo, hi)) begin
      case ($urandom_range(0, 7))
        0:       add_byte(ChHt);
        1:       add_byte(ChCr);
        2:       add_byte(ChVt);
        3:       add_byte(ChFf);
        default: add_byte(ChSp);
      endcase
    end
  endtask

  // Move the assembled buffer into the send queue, tlast on its final byte.
  task automatic flush_line();
    for (int i = 0; i < line_q.size(); i++)
      pending_bytes.push_back(byte_req_t'{data: line_q[i], last: (i == line_q.size() - 1)});
    line_q.delete();
  endtask

  initial begin
    int unsigned random_bytes;
    int unsigned kind;
    int unsigned keep;
    random_bytes = 0;
    clear_parser();

    // Directed: leading CR/LF, valid line with an ignored tail byte
    add_byte(ChCr);
    add_byte(ChLf);
    add_text("A B C");
    add_byte(ChCr);
    add_byte(ChLf);
    add_text("x");
    flush_line();
    // Empty buffer
    add_byte(ChLf);
    flush_line();
    // Extreme bytes, blanks HT, VT and FF, non-LF after the version's blank
    add_byte(8'hFF);
    add_byte(ChHt);
    add_byte(8'h80);
    add_byte(ChVt);
    add_byte(8'h7F);
    add_byte(ChFf);
    add_byte(8'h00);
    flush_line();
    // LF inside the method, buffer ends in the method
    add_text("a");
    add_byte(ChLf);
    flush_line();
    // Buffer ends inside the version
    add_text("a b c");
    flush_line();

    // Random: mostly well-formed lines, some truncated, corrupted or noise
    while (random_bytes < RandomBytes) begin
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
        repeat ($urandom_range(1, 10)) add_byte(DataW'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 2) == 0)
          repeat ($urandom_range(1, 3)) add_byte($urandom_range(0, 1) ? ChCr : ChLf);
        add_token(1, 8);
        add_blanks(1, 3);
        add_token(1, 12);
        add_blanks(1, 3);
        add_token(1, 8);
        add_blanks(1, 2);
        add_byte(ChLf);
        if (kind == 7) begin
          keep = $urandom_range(1, line_q.size());
          while (line_q.size() > keep) void'(line_q.pop_back());
        end else if (kind == 8) begin
          line_q[$urandom_range(0, line_q.size() - 1)] = DataW'($urandom_range(0, 255));
        end
      end
      random_bytes += line_q.size();
      // Bytes after the line are ignored by the parser
      if (kind < 7) repeat ($urandom_range(0, 3)) add_byte(DataW'($urandom_range(0, 255)));
      flush_line();
    end

    total_bytes = pending_bytes.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_accepted < total_bytes) @(posedge clk_i);
    while (expected_lines.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_lines.size() != 0)
      report_mismatch("results never delivered", 0, expected_lines.size());
    if (error_count == 0) begin
      $display("PASS http_request_line_parser_unit");
    end else begin
      $display("FAIL http_request_line_parser_unit");
    end
    $finish;
  end

  // Byte driver: bursts of random length separated by random gaps
  always @(posedge clk_i) begin : drive_bytes
    byte_req_t nxt;
    if (rst_ni && !(s_axis_tvalid && !s_axis_tready)) begin
      if (s_axis_tvalid) begin
        parse_byte(s_axis_tdata, s_axis_tlast);
        bytes_accepted++;
      end
      if (gap_left != 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        nxt = pending_bytes.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt.data;
        s_axis_tlast  <= nxt.last;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          if ($urandom_range(0, 2) == 0) gap_left = 0;
          else gap_left = $urandom_range(1, ($urandom_range(0, 5) == 0) ? 12 : 3);
        end else begin
          burst_left--;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // One long receiver hold-off so the result buffer fills and input stalls
  always @(posedge clk_i) begin
    if (rst_ni && hold_count < HoldCycles && bytes_accepted >= HoldAfter) begin
      hold_count++;
      hold_off <= (hold_count < HoldCycles);
    end
  end

  // Result monitor and receiver stall pattern
  always @(posedge clk_i) begin : watch_results
    result_t         wanted;
    logic [OutW-1:0] got_f [9];
    logic [OutW-1:0] exp_f [9];
    logic            ready_now;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_lines.size() == 0) begin
          report_mismatch("result with none expected", m_axis_tuser, 0);
        end else begin
          wanted = expected_lines.pop_front();
          got_f[0] = m_axis_tuser[0];
          got_f[1] = m_axis_tuser[3:1];
          for (int k = 0; k < 7; k++) got_f[k+2] = m_axis_tdata[k*OutW +: OutW];
          exp_f[0] = wanted.line_ok;
          exp_f[1] = wanted.error_code;
          exp_f[2] = wanted.method_start;
          exp_f[3] = wanted.method_length;
          exp_f[4] = wanted.target_start;
          exp_f[5] = wanted.target_length;
          exp_f[6] = wanted.version_start;
          exp_f[7] = wanted.version_length;
          exp_f[8] = wanted.line_end;
          for (int k = 0; k < 9; k++)
            if (got_f[k] !== exp_f[k]) report_mismatch(slot_name(k), got_f[k], exp_f[k]);
        end
      end
      rx_tick++;
      if (rx_tick % 48 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0:       ready_now = 1'b1;
        1:       ready_now = $urandom_range(0, 1);
        2:       ready_now = (rx_tick % 4) == 0;
        default: ready_now = (rx_tick % 16) < 11;
      endcase
      m_axis_tready <= ready_now && !hold_off;
    end
  end

  // Watchdog: too long without any request moving on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WatchLimit) begin
      $display("FAIL http_request_line_parser_unit");
      $finish;
    end
  end

endmodule

FILE: filelist.f
hdl/hrlp_pkg.sv
hdl/hrlp_core.sv
hdl/http_request_line_parser_unit.sv
test/http_request_line_parser_unit_tb.sv
